/* rtl/awb_pkg.sv */
// Shared types and constants for the white-balance gain calculator.
package awb_pkg;

    localparam int GainW    = 16;
    localparam int DvdW     = 25;
    localparam int DivSteps = DvdW;
    localparam int Latency  = 2 * DivSteps + 1;

    localparam logic [GainW-1:0] UnityGain = 16'h0100;
    localparam logic [GainW-1:0] RatioOne  = 16'd512;
    localparam logic [DvdW-1:0]  GreenDvd  = 25'd131072;

    localparam logic [1:0] StatOk      = 2'd0;
    localparam logic [1:0] StatZeroArg = 2'd1;
    localparam logic [1:0] StatZeroCor = 2'd2;

    localparam logic AddrGoldRed  = 1'b0;
    localparam logic AddrGoldBlue = 1'b1;

    typedef struct packed {
        logic [1:0]       status;
        logic [GainW-1:0] r;
        logic [GainW-1:0] b;
    } side_t;

    typedef struct packed {
        logic             valid;
        logic [GainW-1:0] rem;
        logic [DvdW-1:0]  dq;
        logic [GainW-1:0] dvs;
        side_t            side;
    } div_stage_t;

endpackage

/* rtl/awb_div_cell.sv */
// One restoring division step: one quotient bit per cell.
module awb_div_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  awb_pkg::div_stage_t stage_in,
    output awb_pkg::div_stage_t stage_out
);

    logic [awb_pkg::GainW:0]   cand;
    logic [awb_pkg::GainW+1:0] diff;
    logic                      ge;
    logic                      valid_reg;
    awb_pkg::div_stage_t       data_reg;
    awb_pkg::div_stage_t       data_next;

    assign cand = {stage_in.rem, stage_in.dq[awb_pkg::DvdW-1]};
    assign diff = {1'b0, cand} - {2'b00, stage_in.dvs};
    assign ge   = !diff[awb_pkg::GainW+1];

    always_comb
    begin
        data_next       = stage_in;
        data_next.rem   = ge ? diff[awb_pkg::GainW-1:0] : cand[awb_pkg::GainW-1:0];
        data_next.dq    = {stage_in.dq[awb_pkg::DvdW-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= stage_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_comb
    begin
        stage_out       = data_reg;
        stage_out.valid = valid_reg;
    end

endmodule

/* rtl/awb_div.sv */
// Pipelined divider: a row of division cells, one beat per cycle.
module awb_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [awb_pkg::DvdW-1:0]      dividend,
    input  logic [awb_pkg::GainW-1:0]     divisor,
    input  awb_pkg::side_t                side_in,
    output logic                          out_valid,
    output logic [awb_pkg::DvdW-1:0]      quotient,
    output awb_pkg::side_t                side_out
);

    awb_pkg::div_stage_t stg [0:awb_pkg::DivSteps];

    always_comb
    begin
        stg[0].valid = in_valid;
        stg[0].rem   = '0;
        stg[0].dq    = dividend;
        stg[0].dvs   = divisor;
        stg[0].side  = side_in;
    end

    for (genvar i = 0; i < awb_pkg::DivSteps; i++)
    begin : g_cell
        awb_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .stage_in  (stg[i]),
            .stage_out (stg[i+1])
        );
    end

    assign out_valid = stg[awb_pkg::DivSteps].valid;
    assign quotient  = stg[awb_pkg::DivSteps].dq;
    assign side_out  = stg[awb_pkg::DivSteps].side;

endmodule

/* rtl/awb_channel_gain_calc.sv */
// Top level: white-balance channel gain calculator with APB register port.
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   cmd     | start, busy, measured_red/blue_ratio      | in/out
//   result  | done, status, red/green/blue_gain         | out
//   config  | psel, penable, pwrite, paddr, pwdata, ... | in/out
//
// Each beat passes through two 25-cell divider rows plus an output register.
// One beat accepted every cycle; busy stays low.
// Reset clears valid bits and sets both golden ratios to 512.
// Results strobe for one cycle on done; no back-pressure.
module awb_channel_gain_calc (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [15:0]               measured_red_ratio,
    input  logic [15:0]               measured_blue_ratio,
    output logic                      done,
    output logic [1:0]                status,
    output logic [15:0]               red_gain,
    output logic [15:0]               green_gain,
    output logic [15:0]               blue_gain,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [2:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    logic [15:0] gold_r_reg;
    logic [15:0] gold_b_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign wr_en  = psel && penable && pwrite;
    assign prdata = (paddr[2] == awb_pkg::AddrGoldBlue) ? {16'h0, gold_b_reg}
                                                        : {16'h0, gold_r_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gold_r_reg <= awb_pkg::RatioOne;
            gold_b_reg <= awb_pkg::RatioOne;
        end
        else if (wr_en)
        begin
            if (paddr[2] == awb_pkg::AddrGoldRed)
            begin
                gold_r_reg <= pwdata[15:0];
            end
            else
            begin
                gold_b_reg <= pwdata[15:0];
            end
        end
    end

    // stage 1: correction ratios
    awb_pkg::side_t            s1_side;
    logic                      s1_zero;
    logic                      c_valid;
    logic [awb_pkg::DvdW-1:0]  c_qr;
    logic [awb_pkg::DvdW-1:0]  c_qb;
    awb_pkg::side_t            c_side;

    assign s1_zero = (measured_red_ratio == 16'd0) || (measured_blue_ratio == 16'd0)
                  || (gold_r_reg == 16'd0) || (gold_b_reg == 16'd0);

    always_comb
    begin
        s1_side        = '0;
        s1_side.status = s1_zero ? awb_pkg::StatZeroArg : awb_pkg::StatOk;
    end

    awb_div u_div_r (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .dividend  ({gold_r_reg, 9'd0}),
        .divisor   (measured_red_ratio),
        .side_in   (s1_side),
        .out_valid (c_valid),
        .quotient  (c_qr),
        .side_out  (c_side)
    );

    awb_div u_div_b (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .dividend  ({gold_b_reg, 9'd0}),
        .divisor   (measured_blue_ratio),
        .side_in   (s1_side),
        .out_valid (),
        .quotient  (c_qb),
        .side_out  ()
    );

    // stage 2: gain quotients
    awb_pkg::side_t            s2_side;
    logic [15:0]               r;
    logic [15:0]               b;
    logic                      g_valid;
    logic [awb_pkg::DvdW-1:0]  q_rb;
    logic [awb_pkg::DvdW-1:0]  q_br;
    logic [awb_pkg::DvdW-1:0]  q_gr;
    logic [awb_pkg::DvdW-1:0]  q_gb;
    awb_pkg::side_t            g_side;

    assign r = c_qr[15:0];
    assign b = c_qb[15:0];

    always_comb
    begin
        s2_side   = c_side;
        s2_side.r = r;
        s2_side.b = b;
        if (c_side.status == awb_pkg::StatOk && (r == 16'd0 || b == 16'd0))
        begin
            s2_side.status = awb_pkg::StatZeroCor;
        end
    end

    awb_div u_div_rb (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (c_valid),
        .dividend  ({1'b0, r, 8'd0}),
        .divisor   (b),
        .side_in   (s2_side),
        .out_valid (g_valid),
        .quotient  (q_rb),
        .side_out  (g_side)
    );

    awb_div u_div_br (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (c_valid),
        .dividend  ({1'b0, b, 8'd0}),
        .divisor   (r),
        .side_in   (s2_side),
        .out_valid (),
        .quotient  (q_br),
        .side_out  ()
    );

    awb_div u_div_gr (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (c_valid),
        .dividend  (awb_pkg::GreenDvd),
        .divisor   (r),
        .side_in   (s2_side),
        .out_valid (),
        .quotient  (q_gr),
        .side_out  ()
    );

    awb_div u_div_gb (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (c_valid),
        .dividend  (awb_pkg::GreenDvd),
        .divisor   (b),
        .side_in   (s2_side),
        .out_valid (),
        .quotient  (q_gb),
        .side_out  ()
    );

    // gain selection and output register
    logic        r_big;
    logic        b_big;
    logic        done_reg;
    logic [1:0]  status_reg;
    logic [15:0] red_reg;
    logic [15:0] green_reg;
    logic [15:0] blue_reg;
    logic [15:0] red_next;
    logic [15:0] green_next;
    logic [15:0] blue_next;

    assign r_big = g_side.r >= awb_pkg::RatioOne;
    assign b_big = g_side.b >= awb_pkg::RatioOne;

    always_comb
    begin
        red_next   = awb_pkg::UnityGain;
        green_next = awb_pkg::UnityGain;
        blue_next  = awb_pkg::UnityGain;
        if (g_side.status != awb_pkg::StatOk)
        begin
            red_next   = '0;
            green_next = '0;
            blue_next  = '0;
        end
        else if (r_big && b_big)
        begin
            red_next  = {1'b0, g_side.r[15:1]};
            blue_next = {1'b0, g_side.b[15:1]};
        end
        else if (r_big)
        begin
            red_next   = q_rb[15:0];
            green_next = q_gb[15:0];
        end
        else if (b_big)
        begin
            green_next = q_gr[15:0];
            blue_next  = q_br[15:0];
        end
        else if (q_gr[15:0] >= q_gb[15:0])
        begin
            green_next = q_gr[15:0];
            blue_next  = q_br[15:0];
        end
        else
        begin
            red_next   = q_rb[15:0];
            green_next = q_gb[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= g_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= g_side.status;
        red_reg    <= red_next;
        green_reg  <= green_next;
        blue_reg   <= blue_next;
    end

    assign done       = done_reg;
    assign status     = status_reg;
    assign red_gain   = red_reg;
    assign green_gain = green_reg;
    assign blue_gain  = blue_reg;

`ifndef SYNTHESIS
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> status != 2'd3)
        else $error("bad status code");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != awb_pkg::StatOk |->
            red_gain == 16'd0 && green_gain == 16'd0 && blue_gain == 16'd0)
        else $error("error beat with nonzero gains");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, awb_pkg::Latency))
        else $error("result without matching command");
`endif

endmodule

/* sim/awb_channel_gain_calc_tb.sv */
// Testbench for awb_channel_gain_calc: random and directed ratio beats vs. a gain predictor.
module awb_channel_gain_calc_tb;

    typedef struct {
        logic [1:0]  status;
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
    } gain_set_t;

    class gain_scoreboard;
        gain_set_t pending[$];
        logic [15:0] gold_red = 16'd512;
        logic [15:0] gold_blue = 16'd512;
        int errors = 0;

        function gain_set_t predict(logic [15:0] mr, logic [15:0] mb);
            gain_set_t g;
            logic [31:0] r, b, gr, gb, red, green, blue;
            g.status = awb_pkg::StatOk;
            g.red = '0;
            g.green = '0;
            g.blue = '0;
            if (mr == 0 || mb == 0 || gold_red == 0 || gold_blue == 0)
            begin
                g.status = awb_pkg::StatZeroArg;
                return g;
            end
            r = ((32'd512 * gold_red) / mr) & 32'hFFFF;
            b = ((32'd512 * gold_blue) / mb) & 32'hFFFF;
            if (r == 0 || b == 0)
            begin
                g.status = awb_pkg::StatZeroCor;
                return g;
            end
            if (r >= 512 && b >= 512)
            begin
                red = 256 * r / 512;
                green = 256;
                blue = 256 * b / 512;
            end
            else if (r >= 512)
            begin
                red = 256 * r / b;
                green = 131072 / b;
                blue = 256;
            end
            else if (b >= 512)
            begin
                red = 256;
                green = 131072 / r;
                blue = 256 * b / r;
            end
            else
            begin
                gr = (131072 / r) & 32'hFFFF;
                gb = (131072 / b) & 32'hFFFF;
                if (gr >= gb)
                begin
                    red = 256;
                    green = gr;
                    blue = 256 * b / r;
                end
                else
                begin
                    red = 256 * r / b;
                    green = gb;
                    blue = 256;
                end
            end
            g.red = red[15:0];
            g.green = green[15:0];
            g.blue = blue[15:0];
            return g;
        endfunction

        function void note_ratios(logic [15:0] mr, logic [15:0] mb);
            pending.push_back(predict(mr, mb));
        endfunction

        function void check_gains(logic [1:0] st, logic [15:0] rg, logic [15:0] gg,
                                  logic [15:0] bg);
            gain_set_t e;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected beat: %0d %h %h %h", st, rg, gg, bg);
                return;
            end
            e = pending.pop_front();
            if (st !== e.status || rg !== e.red || gg !== e.green || bg !== e.blue)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp %0d %h %h %h got %0d %h %h %h",
                             e.status, e.red, e.green, e.blue, st, rg, gg, bg);
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        start = 0;
    logic        busy;
    logic [15:0] measured_red_ratio = 0;
    logic [15:0] measured_blue_ratio = 0;
    logic        done;
    logic [1:0]  status;
    logic [15:0] red_gain, green_gain, blue_gain;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [2:0]  paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic        pready;

    gain_scoreboard sb = new();
    int idle_cycles = 0;
    bit calm = 0;

    awb_channel_gain_calc dut (.*);

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && done) sb.check_gains(status, red_gain, green_gain, blue_gain);
        if ((start && !busy) || done) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] addr, input logic [15:0] val);
        @(posedge clk);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= addr;
        pwdata <= {16'($urandom_range(65535)), val};
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        if (addr == 3'd0) sb.gold_red = val;
        else if (addr == 3'd4) sb.gold_blue = val;
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (awb_pkg::Latency + 5) @(posedge clk);
    endtask

    task automatic send_ratio(input logic [15:0] mr, input logic [15:0] mb);
        if (!calm)
        begin
            while ($urandom_range(99) < 23)
            begin
                start <= 0;
                @(posedge clk);
            end
        end
        start <= 1;
        measured_red_ratio <= mr;
        measured_blue_ratio <= mb;
        @(posedge clk);
        while (busy) @(posedge clk);
        sb.note_ratios(mr, mb);
    endtask

    function automatic logic [15:0] pick_ratio();
        case ($urandom_range(5))
            0: return 16'($urandom);
            1: return 16'($urandom_range(1, 64));
            2: return 16'hFFFF - 16'($urandom_range(15));
            3: return 16'd1 << $urandom_range(15);
            default: return 16'($urandom_range(100, 2000));
        endcase
    endfunction

    task automatic stop_driving();
        start <= 0;
        @(posedge clk);
    endtask

    initial
    begin
        logic [15:0] gr_set[6] = '{16'd512, 16'd0, 16'd1, 16'hFFFF, 16'd300, 16'd900};
        logic [15:0] gb_set[6] = '{16'd512, 16'd700, 16'hFFFF, 16'd1, 16'd0, 16'd400};
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        send_ratio(0, 512);
        send_ratio(512, 0);
        send_ratio(512, 512);
        send_ratio(256, 256);
        send_ratio(1024, 1024);
        send_ratio(256, 1024);
        send_ratio(1024, 256);
        send_ratio(300, 700);
        send_ratio(700, 300);
        send_ratio(1, 1);
        send_ratio(16'hFFFF, 16'hFFFF);
        send_ratio(1, 16'hFFFF);
        send_ratio(16'hFFFF, 1);
        send_ratio(128, 8);
        send_ratio(16'hAAAA, 16'h5555);
        send_ratio(16'h5555, 16'hAAAA);
        stop_driving();
        drain();
        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(3'd0, gr_set[ph]);
            write_reg(3'd4, gb_set[ph]);
            calm = (ph == 2);
            for (int i = 0; i < 230; i++) send_ratio(pick_ratio(), pick_ratio());
            calm = 0;
            stop_driving();
            drain();
        end
        write_reg(3'd0, 16'd512);
        write_reg(3'd4, 16'd512);
        for (int i = 0; i < 20; i++) send_ratio(16'($urandom), 16'($urandom));
        stop_driving();
        drain();
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

/* sim.f */
rtl/awb_pkg.sv
rtl/awb_div_cell.sv
rtl/awb_div.sv
rtl/awb_channel_gain_calc.sv
sim/awb_channel_gain_calc_tb.sv
